@@ sv/acir_pkg.sv @@
// Shared types and constants for the air-conditioner IR frame transmitter.
// No dependencies; every other file imports this package.
`default_nettype none

package acir_pkg;

   // Register map of the configuration port
   localparam int unsigned NUM_CSR = 7;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 12;

   localparam logic [CSR_IDX_BITS-1:0] CSR_START_MARK  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_SPACE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONE_MARK    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONE_SPACE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZERO_MARK   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZERO_SPACE  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STOP_MARK   = 3'd6;

   typedef logic [CSR_DATA_BITS-1:0] acir_csr_array_type [NUM_CSR];

   localparam logic [CSR_DATA_BITS-1:0] CSR_RESET [NUM_CSR] = '{
      12'd3168, 12'd568, 12'd394, 12'd1180, 12'd406, 12'd382, 12'd406
   };

   // Frame layout
   localparam int unsigned FRAME_BYTES = 11;
   localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
   localparam logic [6:0]  NBITS       = 7'd88;

   localparam logic [7:0] HDR0 = 8'h52;
   localparam logic [7:0] HDR1 = 8'hAE;
   localparam logic [7:0] HDR2 = 8'hC3;
   localparam logic [7:0] HDR3 = 8'h26;
   localparam logic [7:0] HDR4 = 8'hD9;
   localparam logic [7:0] SWING_ON_A  = 8'h7F;
   localparam logic [7:0] SWING_ON_B  = 8'h80;
   localparam logic [7:0] SWING_OFF_A = 8'hFF;
   localparam logic [7:0] SWING_OFF_B = 8'h00;
   localparam logic [7:0] FAN_LOW_NIB = 8'h0F;
   localparam logic [7:0] VSWING_STEP = 8'h10;
   localparam logic [7:0] FANMODE_A   = 8'h27;
   localparam logic [7:0] FANMODE_B   = 8'hD8;

   // Operating mode codes
   localparam logic [2:0] OM_FAN  = 3'd1;
   localparam logic [2:0] OM_COOL = 3'd2;
   localparam logic [2:0] OM_HEAT = 3'd3;
   localparam logic [2:0] OM_DRY  = 3'd4;
   localparam logic [2:0] OM_OFF  = 3'd5;

   // Fan speed codes
   localparam logic [2:0] FAN_AUTO = 3'd1;
   localparam logic [2:0] FAN_HIGH = 3'd2;
   localparam logic [2:0] FAN_MED  = 3'd3;
   localparam logic [2:0] FAN_LOW  = 3'd4;

   // Item classification
   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // Decoded item passed from the front end to the sequencer
   typedef struct packed {
      logic       is_tick;
      logic [7:0] swing_a;
      logic [7:0] swing_b;
      logic [7:0] fan_a;
      logic [7:0] fan_b;
      logic [3:0] temp_hi_a;
      logic [3:0] temp_hi_b;
      logic [2:0] op_mode;
   } acir_item_type;

   // Configuration write
   typedef struct packed {
      logic                     wr;
      logic [CSR_IDX_BITS-1:0]  idx;
      logic [CSR_DATA_BITS-1:0] data;
   } acir_csr_wr_type;

   // Sequencer phases
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_SMARK  = 6'b000010,
      PH_SSPACE = 6'b000100,
      PH_BMARK  = 6'b001000,
      PH_BSPACE = 6'b010000,
      PH_STOP   = 6'b100000
   } acir_phase_type;

endpackage

`default_nettype wire

@@ sv/acir_front.sv @@
// Front end: classifies an incoming item and precomputes the frame bytes
// that do not depend on sequencer state. Uses acir_pkg.
`default_nettype none

module acir_front
   import acir_pkg::*;
(
   input  wire logic          mode,
   input  wire logic [7:0]    temperature,
   input  wire logic [2:0]    fan_speed,
   input  wire logic          horizontal_swing,
   input  wire logic          vertical_swing,
   input  wire logic [2:0]    operating_mode,
   output acir_item_type      item
);

   logic [7:0] fan_a_raw;
   logic [7:0] fan_b_raw;
   logic [3:0] k;
   logic       temp_ok;

   // Look up the fan byte pair
   always_comb begin
      case (fan_speed)
         FAN_AUTO: begin
            fan_a_raw = 8'hF0;
            fan_b_raw = 8'h00;
         end
         FAN_HIGH: begin
            fan_a_raw = 8'h70;
            fan_b_raw = 8'h80;
         end
         FAN_MED: begin
            fan_a_raw = 8'h90;
            fan_b_raw = 8'h60;
         end
         FAN_LOW: begin
            fan_a_raw = 8'hB0;
            fan_b_raw = 8'h40;
         end
         default: begin
            fan_a_raw = 8'h00;
            fan_b_raw = 8'h00;
         end
      endcase
   end

   // Map the set point to an offset; out of range counts as thirteen
   assign temp_ok = (temperature >= 8'd18) && (temperature <= 8'd30);
   assign k       = temp_ok ? 4'(temperature - 8'd18) : 4'd13;

   // Assemble the decoded item
   always_comb begin
      item.is_tick   = (mode == REQ_TICK);
      item.swing_a   = horizontal_swing ? SWING_ON_A : SWING_OFF_A;
      item.swing_b   = horizontal_swing ? SWING_ON_B : SWING_OFF_B;
      item.fan_a     = vertical_swing ? ((FAN_LOW_NIB | fan_a_raw) - VSWING_STEP)
                                      : (FAN_LOW_NIB | fan_a_raw);
      item.fan_b     = vertical_swing ? (fan_b_raw + VSWING_STEP) : fan_b_raw;
      item.temp_hi_a = 4'(4'd14 - k);
      item.temp_hi_b = 4'(4'd1 + k);
      item.op_mode   = operating_mode;
   end

endmodule

`default_nettype wire

@@ sv/acir_queue.sv @@
// Two-entry queue of decoded items between front end and sequencer.
// Uses acir_pkg for the item type.
`default_nettype none

module acir_queue
   import acir_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  acir_item_type      in_item,
   output logic               out_valid,
   input  wire logic          out_ready,
   output acir_item_type      out_item
);

   acir_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/acir_back.sv @@
// Sequencer: holds configuration, the frame shift register and the envelope
// state machine, and registers one result per item. Uses acir_pkg.
`default_nettype none

module acir_back
   import acir_pkg::*;
#(
   parameter int unsigned DURATION_BITS = 12
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  acir_csr_wr_type    csr_wr,
   input  wire logic          q_valid,
   output logic               q_ready,
   input  acir_item_type      q_item,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_line_level,
   output logic               rsp_busy_res,
   output logic               rsp_accepted,
   output logic               rsp_frame_done
);

   logic [CSR_DATA_BITS-1:0] cfg_ff [NUM_CSR];
   acir_phase_type           phase_ff, phase_in;
   logic [6:0]               bit_index_ff, bit_index_in;
   logic [DURATION_BITS-1:0] time_left_ff, time_left_in;
   logic [DURATION_BITS-1:0] time_dec;
   logic                     line_ff, line_in;
   logic [2:0]               prev_mode_ff, prev_mode_in;
   logic [FRAME_BITS-1:0]    frame_ff, frame_in;
   logic                     frame_load;
   logic                     busy;
   logic                     do_step;
   logic [3:0]               lo_a, lo_b;
   logic [7:0]               byte9, byte10;
   logic                     accepted_in, done_in;

   logic                     rsp_valid_ff;
   logic                     rsp_line_ff, rsp_busy_ff, rsp_acc_ff, rsp_done_ff;

   // Mask a duration to the counter width; zero counts as one tick
   function automatic logic [DURATION_BITS-1:0] load_dur(input logic [CSR_DATA_BITS-1:0] v);
      logic [DURATION_BITS-1:0] d;
      d = DURATION_BITS'(v);
      return (d == '0) ? DURATION_BITS'(1) : d;
   endfunction

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            cfg_ff[i] <= CSR_RESET[i];
         end
      end else if (csr_wr.wr && (csr_wr.idx < CSR_IDX_BITS'(NUM_CSR))) begin
         cfg_ff[csr_wr.idx] <= csr_wr.data;
      end
   end

   // Step when the output register is free or draining
   assign q_ready = !rsp_valid_ff || !rsp_stall;
   assign do_step = q_valid && q_ready;
   assign busy    = (phase_ff != PH_IDLE);
   assign time_dec = time_left_ff - DURATION_BITS'(1);

   // Pick mode nibbles of the last two frame bytes
   always_comb begin
      case (q_item.op_mode)
         OM_COOL: begin
            lo_a = 4'h6;
            lo_b = 4'h9;
         end
         OM_HEAT: begin
            lo_a = 4'h3;
            lo_b = 4'hC;
         end
         OM_DRY: begin
            lo_a = 4'h5;
            lo_b = 4'hA;
         end
         OM_OFF: begin
            case (prev_mode_ff)
               OM_FAN: begin
                  lo_a = 4'hF;
                  lo_b = 4'h0;
               end
               OM_COOL: begin
                  lo_a = 4'hE;
                  lo_b = 4'h1;
               end
               OM_HEAT: begin
                  lo_a = 4'hB;
                  lo_b = 4'h4;
               end
               OM_DRY: begin
                  lo_a = 4'hD;
                  lo_b = 4'h2;
               end
               default: begin
                  lo_a = 4'h0;
                  lo_b = 4'h0;
               end
            endcase
         end
         default: begin
            lo_a = 4'h0;
            lo_b = 4'h0;
         end
      endcase
   end

   assign byte9  = (q_item.op_mode == OM_FAN) ? FANMODE_A : {q_item.temp_hi_a, lo_a};
   assign byte10 = (q_item.op_mode == OM_FAN) ? FANMODE_B : {q_item.temp_hi_b, lo_b};

   // Advance the envelope state machine
   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      time_left_in = time_left_ff;
      line_in      = line_ff;
      prev_mode_in = prev_mode_ff;
      frame_in     = frame_ff;
      frame_load   = 1'b0;
      accepted_in  = 1'b0;
      done_in      = 1'b0;
      if (do_step) begin
         if (!q_item.is_tick) begin
            if (!busy) begin
               frame_load   = 1'b1;
               frame_in     = {byte10, byte9, q_item.fan_b, q_item.fan_a,
                               q_item.swing_b, q_item.swing_a,
                               HDR4, HDR3, HDR2, HDR1, HDR0};
               phase_in     = PH_SMARK;
               bit_index_in = 7'd0;
               time_left_in = load_dur(cfg_ff[CSR_START_MARK]);
               line_in      = 1'b1;
               accepted_in  = 1'b1;
               if ((q_item.op_mode >= OM_FAN) && (q_item.op_mode <= OM_DRY)) begin
                  prev_mode_in = q_item.op_mode;
               end
            end
         end else if (busy) begin
            time_left_in = time_dec;
            if (time_dec == '0) begin
               case (phase_ff)
                  PH_SMARK: begin
                     phase_in     = PH_SSPACE;
                     line_in      = 1'b0;
                     time_left_in = load_dur(cfg_ff[CSR_START_SPACE]);
                  end
                  PH_SSPACE: begin
                     phase_in     = PH_BMARK;
                     line_in      = 1'b1;
                     time_left_in = load_dur(frame_ff[0] ? cfg_ff[CSR_ONE_MARK]
                                                         : cfg_ff[CSR_ZERO_MARK]);
                  end
                  PH_BMARK: begin
                     phase_in     = PH_BSPACE;
                     line_in      = 1'b0;
                     time_left_in = load_dur(frame_ff[0] ? cfg_ff[CSR_ONE_SPACE]
                                                         : cfg_ff[CSR_ZERO_SPACE]);
                  end
                  PH_BSPACE: begin
                     bit_index_in = bit_index_ff + 7'd1;
                     line_in      = 1'b1;
                     frame_load   = 1'b1;
                     frame_in     = frame_ff >> 1;
                     if (bit_index_in >= NBITS) begin
                        phase_in     = PH_STOP;
                        time_left_in = load_dur(cfg_ff[CSR_STOP_MARK]);
                     end else begin
                        phase_in     = PH_BMARK;
                        time_left_in = load_dur(frame_ff[1] ? cfg_ff[CSR_ONE_MARK]
                                                            : cfg_ff[CSR_ZERO_MARK]);
                     end
                  end
                  default: begin
                     phase_in     = PH_IDLE;
                     line_in      = 1'b0;
                     bit_index_in = 7'd0;
                     done_in      = 1'b1;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= 7'd0;
         time_left_ff <= '0;
         line_ff      <= 1'b0;
         prev_mode_ff <= 3'd0;
      end else begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         time_left_ff <= time_left_in;
         line_ff      <= line_in;
         prev_mode_ff <= prev_mode_in;
      end
   end

   // Load or shift the frame
   always_ff @(posedge clock) begin
      if (frame_load) begin
         frame_ff <= frame_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_ready) begin
         rsp_valid_ff <= do_step;
      end
   end

   always_ff @(posedge clock) begin
      if (do_step) begin
         rsp_line_ff <= line_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_acc_ff  <= accepted_in;
         rsp_done_ff <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_line_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_frame_done = rsp_done_ff;

   // A finished frame leaves the line low and the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (!rsp_busy_ff && !rsp_line_ff))
      else $error("frame_done with block still busy or line high");

   // A started frame opens with the start mark
   a_accept_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |-> (rsp_busy_ff && rsp_line_ff && !rsp_done_ff))
      else $error("accepted command did not begin with a mark");

   // Bit counter never runs past the frame
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (bit_index_ff <= NBITS) && (busy || (bit_index_ff == 7'd0)))
      else $error("bit index out of range");

   // The counter never sits at zero during a phase
   a_time_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy |-> (time_left_ff != '0))
      else $error("duration counter empty while busy");

endmodule

`default_nettype wire

@@ sv/ac_ir_frame_transmitter.sv @@
// Top level of the air-conditioner IR frame transmitter: front end, item
// queue and sequencer. Uses acir_pkg, acir_front, acir_queue, acir_back.
//
//   port group   dir   handshake          payload
//   req_*        in    req_valid/stall    mode, temperature, fan_speed, swings, op mode
//   rsp_*        out   rsp_valid/stall    line_level, busy_res, accepted, frame_done
//   csr_*        in    csr_valid/ready    csr_index (3b), csr_data (12b)
//
// One item per clock sustained while rsp_stall is low; the decoder is
// combinational, and the sequencer updates all of its state at once. From
// acceptance an item is registered in a queue slot, then in the result register.
// Synchronous active-high reset restores register defaults and idles the line.
// A stalled result holds the sequencer; the two-entry queue then fills and
// req_stall rises. csr_ready is always high.
`default_nettype none

module ac_ir_frame_transmitter
   import acir_pkg::*;
#(
   parameter int unsigned DURATION_BITS = 12
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [7:0]               req_temperature,
   input  wire logic [2:0]               req_fan_speed,
   input  wire logic                     req_horizontal_swing,
   input  wire logic                     req_vertical_swing,
   input  wire logic [2:0]               req_operating_mode,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_line_level,
   output logic                          rsp_busy_res,
   output logic                          rsp_accepted,
   output logic                          rsp_frame_done,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   acir_item_type   dec_item;
   acir_item_type   q_item;
   logic            q_in_ready;
   logic            q_valid;
   logic            q_ready;
   acir_csr_wr_type csr_wr;

   // Accept configuration every cycle
   assign csr_ready   = 1'b1;
   assign csr_wr.wr   = csr_valid && csr_ready;
   assign csr_wr.idx  = csr_index;
   assign csr_wr.data = csr_data;

   assign req_stall = !q_in_ready;

   acir_front u_front (
      .mode             (req_mode),
      .temperature      (req_temperature),
      .fan_speed        (req_fan_speed),
      .horizontal_swing (req_horizontal_swing),
      .vertical_swing   (req_vertical_swing),
      .operating_mode   (req_operating_mode),
      .item             (dec_item)
   );

   acir_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (q_in_ready),
      .in_item   (dec_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   acir_back #(
      .DURATION_BITS (DURATION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr         (csr_wr),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_accepted   (rsp_accepted),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

@@ test/acir_envelope_checker.sv @@
// Checker for the IR frame transmitter: watches the item, result and register
// channels, predicts each result item from its own copy of the frame state and
// compares it. Depends on acir_pkg.
module acir_envelope_checker
   import acir_pkg::*;
#(
   parameter int unsigned DURATION_BITS = 12
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     req_mode,
   input  wire logic [7:0]               req_temperature,
   input  wire logic [2:0]               req_fan_speed,
   input  wire logic                     req_horizontal_swing,
   input  wire logic                     req_vertical_swing,
   input  wire logic [2:0]               req_operating_mode,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic                     rsp_line_level,
   input  wire logic                     rsp_busy_res,
   input  wire logic                     rsp_accepted,
   input  wire logic                     rsp_frame_done,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   output int                            fail_count,
   output int                            pending_count,
   output logic                          frame_active
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } envelope_sample_type;

   localparam logic [7:0] TEMP_MIN   = 8'd18;
   localparam logic [7:0] TEMP_MAX   = 8'd30;
   localparam logic [3:0] TEMP_OUT_K = 4'd13;

   // Mirror of the block's registers and frame state
   logic [CSR_DATA_BITS-1:0]  timing [NUM_CSR];
   logic [7:0]                frame [FRAME_BYTES];
   logic [2:0]                last_mode;
   acir_phase_type            phase;
   logic [6:0]                bit_no;
   logic [DURATION_BITS-1:0]  ticks_left;
   logic                      line;
   envelope_sample_type       expected_envelope [$];
   int                        errors = 0;

   // Load a duration; a zero register counts as one tick
   function automatic logic [DURATION_BITS-1:0] duration_of(
      input logic [CSR_IDX_BITS-1:0] idx);
      logic [DURATION_BITS-1:0] v;
      v = DURATION_BITS'(timing[idx]);
      return (v == '0) ? DURATION_BITS'(1) : v;
   endfunction

   // Bit being sent, least significant bit of byte 0 first
   function automatic logic current_bit();
      logic [6:0] i;
      i = (bit_no >= NBITS) ? NBITS - 7'd1 : bit_no;
      return frame[i[6:3]][i[2:0]];
   endfunction

   function automatic logic [2:0] bit_mark_reg();
      return current_bit() ? CSR_ONE_MARK : CSR_ZERO_MARK;
   endfunction

   // Build the eleven frame bytes from one command item
   function automatic void compose_frame(input logic [7:0] temp, input logic [2:0] fan,
                                         input logic hsw, input logic vsw,
                                         input logic [2:0] om);
      logic [7:0] fan_hi;
      logic [7:0] fan_lo;
      logic [3:0] k;
      logic [3:0] nib_a;
      logic [3:0] nib_b;
      frame[0] = HDR0;
      frame[1] = HDR1;
      frame[2] = HDR2;
      frame[3] = HDR3;
      frame[4] = HDR4;
      frame[5] = hsw ? SWING_ON_A : SWING_OFF_A;
      frame[6] = hsw ? SWING_ON_B : SWING_OFF_B;
      case (fan)
         FAN_AUTO: {fan_hi, fan_lo} = 16'hF000;
         FAN_HIGH: {fan_hi, fan_lo} = 16'h7080;
         FAN_MED:  {fan_hi, fan_lo} = 16'h9060;
         FAN_LOW:  {fan_hi, fan_lo} = 16'hB040;
         default:  {fan_hi, fan_lo} = 16'h0000;
      endcase
      frame[7] = FAN_LOW_NIB | fan_hi;
      frame[8] = fan_lo;
      // vertical swing moves one step from the first fan byte to the second
      if (vsw) begin
         frame[7] = frame[7] - VSWING_STEP;
         frame[8] = frame[8] + VSWING_STEP;
      end
      k = (temp >= TEMP_MIN && temp <= TEMP_MAX) ? 4'(temp - TEMP_MIN) : TEMP_OUT_K;
      case (om)
         OM_COOL: {nib_a, nib_b} = 8'h69;
         OM_HEAT: {nib_a, nib_b} = 8'h3C;
         OM_DRY:  {nib_a, nib_b} = 8'h5A;
         OM_OFF: begin
            // off reuses the remembered mode
            case (last_mode)
               OM_FAN:  {nib_a, nib_b} = 8'hF0;
               OM_COOL: {nib_a, nib_b} = 8'hE1;
               OM_HEAT: {nib_a, nib_b} = 8'hB4;
               OM_DRY:  {nib_a, nib_b} = 8'hD2;
               default: {nib_a, nib_b} = 8'h00;
            endcase
         end
         default: {nib_a, nib_b} = 8'h00;
      endcase
      frame[9]  = {4'hE - k, nib_a};
      frame[10] = {4'h1 + k, nib_b};
      if (om == OM_FAN) begin
         frame[9]  = FANMODE_A;
         frame[10] = FANMODE_B;
      end
      if (om >= OM_FAN && om <= OM_DRY)
         last_mode = om;
   endfunction

   // Apply one accepted item to the mirror and return its result item
   function automatic envelope_sample_type advance_envelope(
      input logic kind, input logic [7:0] temp, input logic [2:0] fan,
      input logic hsw, input logic vsw, input logic [2:0] om);
      envelope_sample_type r;
      logic                was_busy;
      r = '0;
      was_busy = (phase != PH_IDLE);
      if (!was_busy)
         line = 1'b0;
      if (kind == REQ_COMMAND) begin
         // start a frame unless one is already going
         if (!was_busy) begin
            compose_frame(temp, fan, hsw, vsw, om);
            phase = PH_SMARK;
            bit_no = '0;
            ticks_left = duration_of(CSR_START_MARK);
            line = 1'b1;
            r.accepted = 1'b1;
         end
      end else if (was_busy) begin
         ticks_left = ticks_left - DURATION_BITS'(1);
         if (ticks_left == '0) begin
            case (phase)
               PH_SMARK: begin
                  phase = PH_SSPACE;
                  line = 1'b0;
                  ticks_left = duration_of(CSR_START_SPACE);
               end
               PH_SSPACE: begin
                  phase = PH_BMARK;
                  line = 1'b1;
                  ticks_left = duration_of(bit_mark_reg());
               end
               PH_BMARK: begin
                  phase = PH_BSPACE;
                  line = 1'b0;
                  ticks_left = duration_of(current_bit() ? CSR_ONE_SPACE : CSR_ZERO_SPACE);
               end
               PH_BSPACE: begin
                  bit_no = bit_no + 7'd1;
                  line = 1'b1;
                  if (bit_no >= NBITS) begin
                     phase = PH_STOP;
                     ticks_left = duration_of(CSR_STOP_MARK);
                  end else begin
                     phase = PH_BMARK;
                     ticks_left = duration_of(bit_mark_reg());
                  end
               end
               default: begin
                  phase = PH_IDLE;
                  line = 1'b0;
                  bit_no = '0;
                  r.frame_done = 1'b1;
               end
            endcase
         end
      end
      r.line_level = line;
      r.busy_res = (phase != PH_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic want,
                                       input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      envelope_sample_type got;
      envelope_sample_type want;
      if (reset) begin
         foreach (timing[i])
            timing[i] = CSR_RESET[i];
         foreach (frame[i])
            frame[i] = '0;
         last_mode = '0;
         phase = PH_IDLE;
         bit_no = '0;
         ticks_left = '0;
         line = 1'b0;
         expected_envelope.delete();
      end else begin
         if (csr_valid && csr_ready && (csr_index < CSR_IDX_BITS'(NUM_CSR)))
            timing[csr_index] = csr_data;
         // compare before pushing: an item accepted now cannot answer now
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_line_level, rsp_busy_res, rsp_accepted, rsp_frame_done};
            if (expected_envelope.size() == 0) begin
               $error("result item with no item outstanding: %b", got);
               errors++;
            end else begin
               want = expected_envelope.pop_front();
               check_field("line_level", want.line_level, got.line_level);
               check_field("busy_res", want.busy_res, got.busy_res);
               check_field("accepted", want.accepted, got.accepted);
               check_field("frame_done", want.frame_done, got.frame_done);
            end
         end
         if (req_valid && !req_stall)
            expected_envelope.push_back(advance_envelope(req_mode, req_temperature,
               req_fan_speed, req_horizontal_swing, req_vertical_swing,
               req_operating_mode));
      end
      fail_count    <= errors;
      pending_count <= expected_envelope.size();
      frame_active  <= (phase != PH_IDLE);
   end

endmodule

@@ test/ac_ir_frame_transmitter_tb.sv @@
// Testbench top for the IR frame transmitter: clock, reset, item and register
// stimulus, result stall and verdict. Uses acir_pkg and acir_envelope_checker.
module ac_ir_frame_transmitter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import acir_pkg::*;

   localparam int unsigned DUR_BITS = 12;
   localparam logic [CSR_DATA_BITS-1:0] DUR_MAX = '1;
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES = 60;

   // Codes without a name in the package
   localparam logic [2:0] OM_RSVD7  = 3'd7;
   localparam logic [2:0] FAN_NONE  = 3'd0;
   localparam logic [2:0] FAN_RSVD6 = 3'd6;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = REQ_TICK;
   logic [7:0]               req_temperature = '0;
   logic [2:0]               req_fan_speed = '0;
   logic                     req_horizontal_swing = 1'b0;
   logic                     req_vertical_swing = 1'b0;
   logic [2:0]               req_operating_mode = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_line_level;
   logic                     rsp_busy_res;
   logic                     rsp_accepted;
   logic                     rsp_frame_done;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int   fail_count;
   int   pending_count;
   logic frame_active;
   logic calm = 1'b0;
   logic hold_arm = 1'b0;
   bit   hold_done = 1'b0;
   int   items_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ac_ir_frame_transmitter #(.DURATION_BITS(DUR_BITS)) u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_temperature, .req_fan_speed,
      .req_horizontal_swing, .req_vertical_swing, .req_operating_mode,
      .rsp_valid, .rsp_stall, .rsp_line_level, .rsp_busy_res, .rsp_accepted,
      .rsp_frame_done,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   acir_envelope_checker #(.DURATION_BITS(DUR_BITS)) u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_temperature, .req_fan_speed,
      .req_horizontal_swing, .req_vertical_swing, .req_operating_mode,
      .rsp_valid, .rsp_stall, .rsp_line_level, .rsp_busy_res, .rsp_accepted,
      .rsp_frame_done,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending_count, .frame_active
   );

   // Receiver: random stalls, one long hold-off, none while calm
   initial begin
      forever begin
         @(posedge clock);
         if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 7);
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_item(input logic kind, input logic [7:0] temp,
                            input logic [2:0] fan, input logic hsw, input logic vsw,
                            input logic [2:0] om);
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= kind;
      req_temperature <= temp;
      req_fan_speed <= fan;
      req_horizontal_swing <= hsw;
      req_vertical_swing <= vsw;
      req_operating_mode <= om;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_temperature();
      return ($urandom_range(99) < 75) ? 8'($urandom_range(18, 30)) : 8'($urandom);
   endfunction

   task automatic send_tick();
      send_item(REQ_TICK, 8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom),
                3'($urandom));
   endtask

   task automatic send_random_command();
      send_item(REQ_COMMAND, pick_temperature(), 3'($urandom), 1'($urandom),
                1'($urandom), 3'($urandom));
   endtask

   // Start a frame, poke it with a command while busy, then tick it to the end
   task automatic run_frame(input logic [7:0] temp, input logic [2:0] fan,
                            input logic hsw, input logic vsw, input logic [2:0] om,
                            input int noise_pct);
      bit seen_busy;
      int n;
      seen_busy = 1'b0;
      n = 0;
      send_item(REQ_COMMAND, temp, fan, hsw, vsw, om);
      send_random_command();
      while (1) begin
         if ($urandom_range(99) < noise_pct)
            send_random_command();
         else
            send_tick();
         n++;
         // frame_active trails the items by one, so the last tick may land idle
         if (frame_active)
            seen_busy = 1'b1;
         else if (seen_busy || n > 2)
            break;
      end
   endtask

   // Drain every result, then write all registers and one unused index
   task automatic write_timing(input acir_csr_array_type d);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      foreach (d[i]) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_BITS'(i);
         csr_data <= d[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_BITS'(NUM_CSR);
      csr_data <= CSR_DATA_BITS'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic acir_csr_array_type timing_all(input logic [CSR_DATA_BITS-1:0] v);
      acir_csr_array_type d;
      d = '{default: v};
      return d;
   endfunction

   initial begin
      acir_csr_array_type timing;
      int base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ticks while idle, reset timing
      repeat (3) send_tick();

      // one bits get a longer space so every frame bit shows on the line
      timing = '{12'd1, 12'd1, 12'd1, 12'd2, 12'd1, 12'd1, 12'd1};
      write_timing(timing);
      run_frame(8'd0, FAN_NONE, 1'b0, 1'b0, OM_OFF, 0);
      run_frame(8'd18, FAN_AUTO, 1'b1, 1'b1, OM_FAN, 0);

      // zero registers count as one tick, no idling on either side
      calm <= 1'b1;
      timing = '{12'd0, 12'd0, 12'd0, 12'd2, 12'd0, 12'd0, 12'd0};
      write_timing(timing);
      run_frame(8'd30, FAN_HIGH, 1'b0, 1'b1, OM_OFF, 0);
      run_frame(8'd31, FAN_MED, 1'b1, 1'b0, OM_COOL, 0);
      calm <= 1'b0;

      // zero bits get a longer mark; reserved fan and mode codes
      timing = '{12'd2, 12'd1, 12'd1, 12'd1, 12'd2, 12'd1, 12'd2};
      write_timing(timing);
      run_frame(8'd255, FAN_RSVD6, 1'b0, 1'b1, OM_RSVD7, 0);

      // random frames with short timing, plus idle ticks
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 25) begin
            foreach (timing[i])
               timing[i] = CSR_DATA_BITS'($urandom_range(0, 3));
            write_timing(timing);
         end
         if ($urandom_range(99) < 85) begin
            hold_arm <= 1'b1;
            run_frame(pick_temperature(), 3'($urandom), 1'($urandom), 1'($urandom),
                      3'($urandom), 3);
         end else begin
            repeat ($urandom_range(1, 6)) send_tick();
         end
      end

      // every register at its maximum; leave the frame running
      write_timing(timing_all(DUR_MAX));
      send_random_command();
      repeat (20) send_tick();
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
